// File: sv/fmwd_pkg.sv
// ----------------------------------------------------------------------------
// Flow meter window detector package
// Shared sizes, register defaults, microcode field codes and the program ROM.
// ----------------------------------------------------------------------------
package fmwd_pkg;

	// Window and field sizes.
	localparam int WINDOW_DEPTH = 10;
	localparam int PULSE_W      = 16;
	localparam int PTR_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int TOTAL_RAW_W  = $clog2(WINDOW_DEPTH * 65535 + 1);
	localparam int TOTAL_W      = (TOTAL_RAW_W > 20) ? TOTAL_RAW_W : 20;
	localparam int SUM_W        = 20;
	localparam logic [SUM_W-1:0] SUM_MAX = 20'hFFFFF;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_START_THRESHOLD  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT_MS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LITERS_PER_PULSE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_SCALE       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_TOTAL    = 3'd4;

	// Register defaults.
	localparam logic [19:0] THRESH_RST = 20'd5;
	localparam logic [31:0] TIMEOUT_RST = 32'd3000;
	localparam logic [31:0] LPP_RST = 32'd10845877;
	localparam logic [23:0] SCALE_RST = 24'd9930;
	localparam logic [63:0] INIT_TOTAL_RST = 64'd0;

	// Smoothing weights out of 256.
	localparam logic [31:0] RATE_OLD_WT = 32'd179;
	localparam logic [31:0] RATE_NEW_WT = 32'd77;

	// Datapath operation codes.
	typedef logic [2:0] op_t;
	localparam op_t OP_NOP    = 3'd0;
	localparam op_t OP_RING   = 3'd1;
	localparam op_t OP_DECIDE = 3'd2;
	localparam op_t OP_CREDIT = 3'd3;
	localparam op_t OP_SAT    = 3'd4;
	localparam op_t OP_MIXA   = 3'd5;
	localparam op_t OP_MIXB   = 3'd6;
	localparam op_t OP_CLEAR  = 3'd7;

	// Multiplier operand selection.
	typedef logic [2:0] mul_sel_t;
	localparam mul_sel_t MUL_NONE      = 3'd0;
	localparam mul_sel_t MUL_TICK      = 3'd1;
	localparam mul_sel_t MUL_SUM_LPP   = 3'd2;
	localparam mul_sel_t MUL_SUM_SCALE = 3'd3;
	localparam mul_sel_t MUL_RATE      = 3'd4;
	localparam mul_sel_t MUL_INST      = 3'd5;

	// Jump conditions.
	typedef logic [1:0] cond_t;
	localparam cond_t COND_NEXT   = 2'd0;
	localparam cond_t COND_ALWAYS = 2'd1;
	localparam cond_t COND_CMD    = 2'd2;

	// Program steps.
	localparam int STEP_W = 4;
	typedef logic [STEP_W-1:0] step_t;
	localparam step_t STEP_IDLE   = 4'd0;
	localparam step_t STEP_RING   = 4'd1;
	localparam step_t STEP_DECIDE = 4'd2;
	localparam step_t STEP_CREDIT = 4'd3;
	localparam step_t STEP_SAT    = 4'd4;
	localparam step_t STEP_MIXA   = 4'd5;
	localparam step_t STEP_MIXB   = 4'd6;
	localparam step_t STEP_OUT    = 4'd7;
	localparam step_t STEP_CLEAR  = 4'd8;

	// One control word of the program.
	typedef struct packed {
		logic     wait_in;
		logic     wait_out;
		op_t      op;
		mul_sel_t mul_sel;
		cond_t    cond;
		step_t    target;
	} ctrl_t;

	// Microcode ROM.
	function automatic ctrl_t ucode_rom(input step_t step);
		ctrl_t w;
		unique case (step)
			STEP_IDLE:   w = '{1'b1, 1'b0, OP_NOP, MUL_NONE, COND_CMD, STEP_CLEAR};
			STEP_RING:   w = '{1'b0, 1'b0, OP_RING, MUL_TICK, COND_NEXT, STEP_IDLE};
			STEP_DECIDE: w = '{1'b0, 1'b0, OP_DECIDE, MUL_SUM_LPP, COND_NEXT, STEP_IDLE};
			STEP_CREDIT: w = '{1'b0, 1'b0, OP_CREDIT, MUL_SUM_SCALE, COND_NEXT, STEP_IDLE};
			STEP_SAT:    w = '{1'b0, 1'b0, OP_SAT, MUL_RATE, COND_NEXT, STEP_IDLE};
			STEP_MIXA:   w = '{1'b0, 1'b0, OP_MIXA, MUL_INST, COND_NEXT, STEP_IDLE};
			STEP_MIXB:   w = '{1'b0, 1'b0, OP_MIXB, MUL_NONE, COND_NEXT, STEP_IDLE};
			STEP_OUT:    w = '{1'b0, 1'b1, OP_NOP, MUL_NONE, COND_ALWAYS, STEP_IDLE};
			STEP_CLEAR:  w = '{1'b0, 1'b0, OP_CLEAR, MUL_NONE, COND_ALWAYS, STEP_OUT};
			default:     w = '{1'b0, 1'b0, OP_NOP, MUL_NONE, COND_ALWAYS, STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

// File: sv/fmwd_seq.sv
// ----------------------------------------------------------------------------
// Flow meter microcode sequencer
// Step counter over the program ROM, with hold and conditional jumps.
// ----------------------------------------------------------------------------
module fmwd_seq import fmwd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_accept,
	input  logic  command,
	input  logic  out_free,
	output ctrl_t ctrl
);

	step_t step_q;
	logic  hold;
	logic  jump;

	// Fetch the control word for the current step.
	always_comb begin
		ctrl = ucode_rom(step_q);
	end

	// A step holds while it waits for a request or for room at the output.
	always_comb begin
		hold = (ctrl.wait_in && !in_accept) || (ctrl.wait_out && !out_free);
		jump = (ctrl.cond == COND_ALWAYS) || ((ctrl.cond == COND_CMD) && command);
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else if (!hold) begin
			if (jump) begin
				step_q <= ctrl.target;
			end else begin
				step_q <= step_q + step_t'(1);
			end
		end
	end

endmodule

// File: sv/fmwd_dp.sv
// ----------------------------------------------------------------------------
// Flow meter datapath
// Configuration registers, bucket ring, shared multiplier and flow state.
// ----------------------------------------------------------------------------
module fmwd_dp import fmwd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data,
	input  logic                 in_accept,
	input  logic [PULSE_W-1:0]   tick_pulses,
	input  logic [31:0]          now_ms,
	input  ctrl_t                ctrl,
	output logic                 flow_q,
	output logic [31:0]          rate_q,
	output logic [63:0]          vol_q,
	output logic [31:0]          start_q
);

	// Configuration registers.
	logic [19:0] thresh_q;
	logic [31:0] timeout_q;
	logic [31:0] lpp_q;
	logic [23:0] scale_q;

	// Latched request fields.
	logic [PULSE_W-1:0] pulses_q;
	logic [31:0]        now_q;

	// Window state.
	logic [PULSE_W-1:0] bucket_q [WINDOW_DEPTH];
	logic [PTR_W-1:0]   ptr_q;
	logic [TOTAL_W-1:0] wt_q;
	logic [TOTAL_W-1:0] wt_next;
	logic [SUM_W-1:0]   sum_q;

	// Flow state and working registers.
	logic [31:0] last_q;
	logic        credit_q;
	logic [31:0] inst_q;
	logic [39:0] mix_q;
	logic [40:0] mix_sum;
	logic [63:0] prod_q;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic        over_thresh;
	logic        idle_expired;

	// New window total once the oldest bucket is replaced, threshold and idle tests, and the rate mix sum.
	always_comb begin
		wt_next = wt_q - TOTAL_W'(bucket_q[ptr_q]) + TOTAL_W'(pulses_q);
		over_thresh = (sum_q >= thresh_q);
		idle_expired = ((now_q - last_q) >= timeout_q);
		mix_sum = {1'b0, mix_q} + prod_q[40:0];
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ctrl.mul_sel)
			MUL_TICK: begin
				mul_a = 32'(pulses_q);
				mul_b = lpp_q;
			end
			MUL_SUM_LPP: begin
				mul_a = 32'(sum_q);
				mul_b = lpp_q;
			end
			MUL_SUM_SCALE: begin
				mul_a = 32'(sum_q);
				mul_b = 32'(scale_q);
			end
			MUL_RATE: begin
				mul_a = rate_q;
				mul_b = RATE_OLD_WT;
			end
			MUL_INST: begin
				mul_a = inst_q;
				mul_b = RATE_NEW_WT;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Product register.
	always_ff @(posedge clk) begin
		if (ctrl.mul_sel != MUL_NONE) begin
			prod_q <= 64'(mul_a) * 64'(mul_b);
		end
	end

	// Request fields are captured as the request is taken.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			pulses_q <= tick_pulses;
			now_q <= now_ms;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RST;
			timeout_q <= TIMEOUT_RST;
			lpp_q <= LPP_RST;
			scale_q <= SCALE_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_START_THRESHOLD:  thresh_q <= cfg_data[19:0];
				REG_IDLE_TIMEOUT_MS:  timeout_q <= cfg_data[31:0];
				REG_LITERS_PER_PULSE: lpp_q <= cfg_data[31:0];
				REG_RATE_SCALE:       scale_q <= cfg_data[23:0];
				default: begin
				end
			endcase
		end
	end

	// Bucket ring and running window sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_DEPTH; i++) begin
				bucket_q[i] <= '0;
			end
			ptr_q <= '0;
			wt_q <= '0;
		end else if (ctrl.op == OP_RING) begin
			bucket_q[ptr_q] <= pulses_q;
			wt_q <= wt_next;
			if (ptr_q == PTR_W'(WINDOW_DEPTH - 1)) begin
				ptr_q <= '0;
			end else begin
				ptr_q <= ptr_q + PTR_W'(1);
			end
		end
	end

	// Saturated window sum used for the threshold, the start credit and the rate.
	always_ff @(posedge clk) begin
		if (ctrl.op == OP_RING) begin
			if (wt_next > TOTAL_W'(SUM_MAX)) begin
				sum_q <= SUM_MAX;
			end else begin
				sum_q <= wt_next[SUM_W-1:0];
			end
		end
	end

	// Flow detection, volume and smoothed rate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flow_q <= 1'b0;
			start_q <= '0;
			last_q <= '0;
			vol_q <= INIT_TOTAL_RST;
			rate_q <= '0;
			credit_q <= 1'b0;
		end else if (cfg_write && (cfg_index == REG_INITIAL_TOTAL)) begin
			vol_q <= cfg_data;
		end else begin
			case (ctrl.op)
				OP_DECIDE: begin
					// The product holds this tick's pulses times volume per pulse.
					if (flow_q) begin
						vol_q <= vol_q + prod_q;
					end
					credit_q <= over_thresh && !flow_q;
					if (over_thresh) begin
						if (!flow_q) begin
							flow_q <= 1'b1;
							start_q <= now_q;
						end
						last_q <= now_q;
					end else if (flow_q && idle_expired) begin
						flow_q <= 1'b0;
						start_q <= '0;
					end
				end
				OP_CREDIT: begin
					// On flow start the whole window is credited once.
					if (credit_q) begin
						vol_q <= vol_q + prod_q;
					end
				end
				OP_MIXB: begin
					if (flow_q) begin
						rate_q <= mix_sum[39:8];
					end else begin
						rate_q <= '0;
					end
				end
				OP_CLEAR: begin
					vol_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Instant rate saturation and the first smoothing term.
	always_ff @(posedge clk) begin
		if (ctrl.op == OP_SAT) begin
			if (prod_q[63:32] != 32'd0) begin
				inst_q <= '1;
			end else begin
				inst_q <= prod_q[31:0];
			end
		end
		if (ctrl.op == OP_MIXA) begin
			mix_q <= prod_q[39:0];
		end
	end

endmodule

// File: sv/flow_meter_window_detector_top.sv
// ----------------------------------------------------------------------------
// Flow meter window detector
// A control tick runs the ring, decide, credit, saturate, mix and output steps
// of the microcode program around one shared 32x32 multiplier; a clear command
// runs the clear and output steps. The next request is taken only once the
// program is back at its idle step, also while the previous result still
// waits in the output register.
// Reset is asynchronous: flow state clears and configuration registers load their defaults.
// ----------------------------------------------------------------------------
module flow_meter_window_detector_top import fmwd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 command,
	input  logic [PULSE_W-1:0]   tick_pulses,
	input  logic [31:0]          now_ms,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 is_flowing,
	output logic [31:0]          flow_rate,
	output logic [63:0]          total_volume,
	output logic [31:0]          flow_start_ms
);

	ctrl_t       ctrl;
	logic        in_accept;
	logic        out_free;
	logic        out_load;
	logic        out_valid_q;
	logic        flow_q;
	logic [31:0] rate_q;
	logic [63:0] vol_q;
	logic [31:0] start_q;
	logic        flowing_q;
	logic [31:0] rate_out_q;
	logic [63:0] vol_out_q;
	logic [31:0] start_out_q;

	// Request handshake.
	always_comb begin
		in_stall = !ctrl.wait_in;
		in_accept = in_valid && !in_stall;
		out_free = !out_valid_q || !out_stall;
		out_load = ctrl.wait_out && out_free;
	end

	fmwd_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.command   (command),
		.out_free  (out_free),
		.ctrl      (ctrl)
	);

	fmwd_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_accept   (in_accept),
		.tick_pulses (tick_pulses),
		.now_ms      (now_ms),
		.ctrl        (ctrl),
		.flow_q      (flow_q),
		.rate_q      (rate_q),
		.vol_q       (vol_q),
		.start_q     (start_q)
	);

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (out_load) begin
			flowing_q <= flow_q;
			rate_out_q <= rate_q;
			vol_out_q <= vol_q;
			start_out_q <= start_q;
		end
	end

	assign out_valid = out_valid_q;
	assign is_flowing = flowing_q;
	assign flow_rate = rate_out_q;
	assign total_volume = vol_out_q;
	assign flow_start_ms = start_out_q;

	// While idle the start stamp reads zero.
	a_idle_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !is_flowing) |-> (flow_start_ms == 32'd0))
		else $error("start stamp not cleared while idle");

	// While idle the rate reads zero.
	a_idle_rate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !is_flowing) |-> (flow_rate == 32'd0))
		else $error("rate not zero while idle");

	// Only one request is in work at a time.
	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> in_stall)
		else $error("request taken while another is in work");

endmodule

// File: tb/flow_meter_window_detector_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Flow meter window detector testbench
// Drives ticks and clear requests through the valid/stall handshake, with
// random idling on both sides, and writes the configuration registers between
// phases. Every result is checked field by field against a fixed expected value
// or a cycle-free model of the pulse window, flow detection, volume and rate.
// ----------------------------------------------------------------------------
module flow_meter_window_detector_top_tb;
	import fmwd_pkg::*;

	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;
	localparam int PHASES = 6;
	localparam int ITEMS_PER_PHASE = 88;
	localparam int SETTLE_CYCLES = 12;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic        flowing;
		logic [31:0] rate;
		logic [63:0] volume;
		logic [31:0] start;
	} meter_result_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
	typedef enum logic [1:0] {QUIET, TRICKLE, STEADY, SURGE} traffic_t;

	typedef struct {
		row_kind_t             kind;
		logic                  cmd;
		logic [PULSE_W-1:0]    pulses;
		logic [31:0]           stamp;
		logic [CFG_IDX_W-1:0]  idx;
		logic [63:0]           value;
		bit                    typed;
		meter_result_t         want;
	} stim_row_t;

	// Block ports.
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [63:0]          cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 command = CMD_TICK;
	logic [PULSE_W-1:0]   tick_pulses = '0;
	logic [31:0]          now_ms = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 is_flowing;
	logic [31:0]          flow_rate;
	logic [63:0]          total_volume;
	logic [31:0]          flow_start_ms;

	// Model of the meter: registers and state.
	logic [19:0]        meter_threshold;
	logic [31:0]        meter_timeout;
	logic [31:0]        meter_lpp;
	logic [23:0]        meter_scale;
	logic [PULSE_W-1:0] meter_ring [WINDOW_DEPTH];
	int                 meter_ptr;
	logic [31:0]        meter_window;
	logic               meter_flowing;
	logic [31:0]        meter_start;
	logic [31:0]        meter_last_active;
	logic [63:0]        meter_volume;
	logic [31:0]        meter_rate;

	meter_result_t pending_readings [$];
	int fault_count = 0;
	int gap_before = 0;
	bit calm = 1'b0;

	flow_meter_window_detector_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .tick_pulses(tick_pulses), .now_ms(now_ms),
		.out_valid(out_valid), .out_stall(out_stall),
		.is_flowing(is_flowing), .flow_rate(flow_rate),
		.total_volume(total_volume), .flow_start_ms(flow_start_ms)
	);

	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("FAIL flow_meter_window_detector_top");
		$finish;
	end

	// Bring the model to its reset state.
	function automatic void reset_meter();
		meter_threshold = THRESH_RST;
		meter_timeout = TIMEOUT_RST;
		meter_lpp = LPP_RST;
		meter_scale = SCALE_RST;
		foreach (meter_ring[i]) meter_ring[i] = '0;
		meter_ptr = 0;
		meter_window = '0;
		meter_flowing = 1'b0;
		meter_start = '0;
		meter_last_active = '0;
		meter_volume = INIT_TOTAL_RST;
		meter_rate = '0;
	endfunction

	// Register write as seen by the model; the initial total also reloads the volume.
	function automatic void meter_config(input logic [CFG_IDX_W-1:0] idx,
	                                     input logic [63:0] value);
		case (idx)
			REG_START_THRESHOLD:  meter_threshold = value[19:0];
			REG_IDLE_TIMEOUT_MS:  meter_timeout = value[31:0];
			REG_LITERS_PER_PULSE: meter_lpp = value[31:0];
			REG_RATE_SCALE:       meter_scale = value[23:0];
			REG_INITIAL_TOTAL:    meter_volume = value;
			default: ;
		endcase
	endfunction

	// One accepted request: update the window, flow state, volume and rate.
	function automatic meter_result_t meter_step(input logic cmd,
	                                             input logic [PULSE_W-1:0] pulses,
	                                             input logic [31:0] stamp);
		logic [31:0] window_sum;
		logic [31:0] idle_ms;
		logic [63:0] inst_rate;
		meter_result_t res;
		if (cmd == CMD_CLEAR) begin
			meter_volume = '0;
		end else begin
			meter_window = meter_window - 32'(meter_ring[meter_ptr]) + 32'(pulses);
			meter_ring[meter_ptr] = pulses;
			meter_ptr = (meter_ptr == WINDOW_DEPTH - 1) ? 0 : meter_ptr + 1;
			window_sum = (meter_window > 32'(SUM_MAX)) ? 32'(SUM_MAX) : meter_window;

			if (meter_flowing)
				meter_volume = meter_volume + 64'(pulses) * 64'(meter_lpp);

			idle_ms = stamp - meter_last_active;
			if (window_sum >= 32'(meter_threshold)) begin
				// On the starting tick the whole window is credited, this tick included.
				if (!meter_flowing) begin
					meter_flowing = 1'b1;
					meter_start = stamp;
					meter_volume = meter_volume + 64'(window_sum) * 64'(meter_lpp);
				end
				meter_last_active = stamp;
			end else if (meter_flowing && idle_ms >= meter_timeout) begin
				meter_flowing = 1'b0;
				meter_start = '0;
			end

			inst_rate = 64'(window_sum) * 64'(meter_scale);
			if (inst_rate > 64'h0000_0000_FFFF_FFFF)
				inst_rate = 64'h0000_0000_FFFF_FFFF;
			if (meter_flowing)
				meter_rate = 32'((64'(RATE_OLD_WT) * 64'(meter_rate)
				                  + 64'(RATE_NEW_WT) * inst_rate) >> 8);
			else
				meter_rate = '0;
		end
		res.flowing = meter_flowing;
		res.rate = meter_rate;
		res.volume = meter_volume;
		res.start = meter_start;
		return res;
	endfunction

	function automatic void note_fault(input string what, input logic [63:0] want,
	                                   input logic [63:0] got);
		fault_count++;
		if (fault_count <= MAX_REPORTS)
			$display("mismatch on %s: expected %0h, got %0h", what, want, got);
	endfunction

	// Result checker: each accepted result against the oldest expectation.
	always @(posedge clk) begin : result_check
		meter_result_t want;
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (pending_readings.size() == 0) begin
				note_fault("result with no request pending", '0, '0);
			end else begin
				want = pending_readings.pop_front();
				if (is_flowing !== want.flowing)
					note_fault("is_flowing", 64'(want.flowing), 64'(is_flowing));
				if (flow_rate !== want.rate)
					note_fault("flow_rate", 64'(want.rate), 64'(flow_rate));
				if (total_volume !== want.volume)
					note_fault("total_volume", want.volume, total_volume);
				if (flow_start_ms !== want.start)
					note_fault("flow_start_ms", 64'(want.start), 64'(flow_start_ms));
			end
		end
	end

	// Receiver back-pressure: random stall bursts, long free stretches now and then.
	initial begin : stall_gen
		int free_len;
		forever begin
			free_len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
			                                       : $urandom_range(1, 16);
			out_stall <= 1'b0;
			repeat (free_len) @(posedge clk);
			if (!calm) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	// Present one request and hold it until taken. Valid drops afterwards only
	// when a gap follows or the caller needs the sender quiet.
	task automatic send_request(input logic cmd, input logic [PULSE_W-1:0] pulses,
	                            input logic [31:0] stamp, input bit typed,
	                            input meter_result_t want, input bit stop_after);
		meter_result_t predicted;
		repeat (gap_before) @(posedge clk);
		in_valid <= 1'b1;
		command <= cmd;
		tick_pulses <= pulses;
		now_ms <= stamp;
		do @(posedge clk); while (in_stall);
		predicted = meter_step(cmd, pulses, stamp);
		pending_readings.push_back(typed ? want : predicted);
		gap_before = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
		if (stop_after || gap_before != 0)
			in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_readings.size() != 0) @(posedge clk);
	endtask

	// Quiet point for register writes: all results in and the block back at rest.
	task automatic settle();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		meter_config(idx, value);
	endtask

	function automatic stim_row_t item_row(input logic cmd, input logic [PULSE_W-1:0] pulses,
	                                       input logic [31:0] stamp, input bit zero_result);
		stim_row_t row;
		row.kind = ROW_ITEM;
		row.cmd = cmd;
		row.pulses = pulses;
		row.stamp = stamp;
		row.idx = '0;
		row.value = '0;
		row.typed = zero_result;
		row.want = '0;
		return row;
	endfunction

	function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
	                                      input logic [63:0] value);
		stim_row_t row;
		row = item_row(CMD_TICK, '0, '0, 1'b0);
		row.kind = ROW_CFG;
		row.idx = idx;
		row.value = value;
		return row;
	endfunction

	// Main sequence.
	initial begin : stimulus
		stim_row_t plan [$];
		logic [19:0] thr;
		logic [31:0] tmo;
		logic [31:0] lpp;
		logic [23:0] scl;
		logic [63:0] init_total;
		logic [31:0] clock_ms;
		logic [PULSE_W-1:0] pulses;
		logic cmd;
		traffic_t mode;
		int run_left;
		int pause_at;
		int roll;
		bit stop_after;

		reset_meter();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. Quiet ticks and a clear from reset give all-zero results.
		plan.push_back(item_row(CMD_TICK, 16'd0, 32'd0, 1'b1));
		plan.push_back(item_row(CMD_CLEAR, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
		plan.push_back(item_row(CMD_TICK, 16'd4, 32'd100, 1'b1));
		// Window reaches the threshold: flow starts and the window is credited.
		plan.push_back(item_row(CMD_TICK, 16'd1, 32'd200, 1'b0));
		// Full-scale pulses fill the ring; the instant rate saturates.
		for (int i = 0; i < WINDOW_DEPTH; i++)
			plan.push_back(item_row(CMD_TICK, 16'hFFFF, 32'd300 + 32'(i) * 32'd100, 1'b0));
		// Clear while flowing, then time up to the wrap point.
		plan.push_back(item_row(CMD_CLEAR, 16'h1234, 32'h0000_1234, 1'b0));
		plan.push_back(item_row(CMD_TICK, 16'd0, 32'hFFFF_FF00, 1'b0));
		plan.push_back(item_row(CMD_TICK, 16'd7, 32'hFFFF_FFFF, 1'b0));
		// Unreachable threshold: idle time measured across the wrap, then timeout.
		plan.push_back(cfg_row(REG_START_THRESHOLD, 64'hF_FFFF));
		plan.push_back(item_row(CMD_TICK, 16'd1, 32'h0000_0100, 1'b0));
		plan.push_back(item_row(CMD_TICK, 16'd0, 32'h0000_1000, 1'b0));
		// Zero threshold and zero timeout: every tick counts as active.
		plan.push_back(cfg_row(REG_START_THRESHOLD, 64'd0));
		plan.push_back(cfg_row(REG_IDLE_TIMEOUT_MS, 64'd0));
		plan.push_back(item_row(CMD_TICK, 16'd0, 32'd5, 1'b0));
		plan.push_back(item_row(CMD_TICK, 16'd0, 32'd0, 1'b0));
		// Register maxima apart from a threshold of one, with the volume reloaded to its top value so it wraps.
		plan.push_back(cfg_row(REG_START_THRESHOLD, 64'd1));
		plan.push_back(cfg_row(REG_IDLE_TIMEOUT_MS, 64'hFFFF_FFFF));
		plan.push_back(cfg_row(REG_LITERS_PER_PULSE, 64'hFFFF_FFFF));
		plan.push_back(cfg_row(REG_RATE_SCALE, 64'hFF_FFFF));
		plan.push_back(cfg_row(REG_INITIAL_TOTAL, 64'hFFFF_FFFF_FFFF_FFFF));
		plan.push_back(item_row(CMD_TICK, 16'hFFFF, 32'h8000_0000, 1'b0));
		plan.push_back(item_row(CMD_CLEAR, 16'd0, 32'd0, 1'b0));
		// Register minima.
		plan.push_back(cfg_row(REG_LITERS_PER_PULSE, 64'd0));
		plan.push_back(cfg_row(REG_RATE_SCALE, 64'd0));
		plan.push_back(cfg_row(REG_INITIAL_TOTAL, 64'd0));
		plan.push_back(item_row(CMD_TICK, 16'd3, 32'h8000_0064, 1'b0));

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				if (i == 0 || plan[i-1].kind != ROW_CFG)
					settle();
				write_register(plan[i].idx, plan[i].value);
				if (i + 1 == plan.size() || plan[i+1].kind != ROW_CFG)
					cfg_write <= 1'b0;
			end else begin
				stop_after = (i + 1 == plan.size()) || (plan[i+1].kind == ROW_CFG);
				send_request(plan[i].cmd, plan[i].pulses, plan[i].stamp,
				             plan[i].typed, plan[i].want, stop_after);
			end
		end

		// Random phases, each under its own register setting; the last runs without idling.
		for (int phase = 0; phase < PHASES; phase++) begin
			calm = (phase == PHASES - 1);
			settle();
			case (phase)
				0: begin
					thr = 20'($urandom_range(1, 40));
					tmo = $urandom_range(100, 3000);
					lpp = $urandom;
					scl = 24'($urandom_range(0, 65535));
					init_total = {$urandom, $urandom};
				end
				1: begin
					thr = 20'd100000;
					tmo = $urandom_range(200, 1000);
					lpp = 32'hFFFF_FFFF;
					scl = 24'hFF_FFFF;
					init_total = 64'hFFFF_FFFF_FFFF_FFFF;
				end
				2: begin
					thr = '0;
					tmo = '0;
					lpp = '0;
					scl = '0;
					init_total = '0;
				end
				default: begin
					thr = ($urandom_range(0, 3) == 0) ? 20'($urandom_range(0, 2000))
					                                   : 20'($urandom_range(1, 30));
					tmo = $urandom_range(0, 4000);
					lpp = $urandom;
					scl = 24'($urandom_range(0, 24'hFF_FFFF));
					init_total = {$urandom, $urandom};
				end
			endcase
			write_register(REG_START_THRESHOLD, 64'(thr));
			write_register(REG_IDLE_TIMEOUT_MS, 64'(tmo));
			write_register(REG_LITERS_PER_PULSE, 64'(lpp));
			write_register(REG_RATE_SCALE, 64'(scl));
			write_register(REG_INITIAL_TOTAL, init_total);
			cfg_write <= 1'b0;

			// Phase three starts just short of the millisecond wrap.
			clock_ms = (phase == 3) ? 32'hFFFF_F000 : $urandom;
			pause_at = $urandom_range(10, ITEMS_PER_PHASE - 10);
			run_left = 0;
			mode = QUIET;

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// Traffic comes in runs: quiet spells, trickles, steady flow and surges.
				if (run_left == 0) begin
					mode = traffic_t'($urandom_range(0, 3));
					run_left = $urandom_range(3, 20);
				end
				run_left--;
				case (mode)
					QUIET:   pulses = ($urandom_range(0, 7) == 0) ? 16'd1 : 16'd0;
					TRICKLE: pulses = 16'($urandom_range(0, 8));
					STEADY:  pulses = 16'($urandom_range(0, 300));
					default: pulses = ($urandom_range(0, 3) == 0) ? 16'hFFFF
					                                               : 16'($urandom_range(0, 65535));
				endcase

				// Ticks about every 100 ms, with occasional long silences and jumps.
				roll = $urandom_range(0, 49);
				if (roll == 0)
					clock_ms = $urandom;
				else if (roll < 6)
					clock_ms = clock_ms + 32'($urandom_range(0, 8000));
				else
					clock_ms = clock_ms + 32'($urandom_range(80, 120));

				cmd = ($urandom_range(0, 24) == 0) ? CMD_CLEAR : CMD_TICK;
				stop_after = (n == ITEMS_PER_PHASE - 1) || (n == pause_at);
				send_request(cmd, pulses, clock_ms, 1'b0, '0, stop_after);
				// The sender holds off once per phase until every result is in.
				if (n == pause_at)
					wait_drained();
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_readings.size() != 0)
			note_fault("results still outstanding", 64'(pending_readings.size()), '0);
		if (fault_count == 0)
			$display("PASS flow_meter_window_detector_top");
		else
			$display("FAIL flow_meter_window_detector_top");
		$finish;
	end

endmodule

// File: flow_meter_window_detector_top.f
sv/fmwd_pkg.sv
sv/fmwd_seq.sv
sv/fmwd_dp.sv
sv/flow_meter_window_detector_top.sv
tb/flow_meter_window_detector_top_tb.sv
